>>> hdl/adsbtt_pkg.sv
package adsbtt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int IN_BITS  = 112;
    localparam int OUT_BITS = 184;

    // Character set of the identification message, code 0 in the top byte.
    localparam logic [511:0] GLYPH_ROM =
        "#ABCDEFGHIJKLMNOPQRSTUVWXYZ##### ###############0123456789######";

    localparam logic [16:0] ALT_STEP   = 17'd25;
    localparam logic [16:0] ALT_OFFSET = 17'd1000;

    localparam logic [25:0] CPR_HALF     = 26'd65536;
    localparam logic [30:0] LAT_WRAP_AT  = 31'd347996160;
    localparam logic [30:0] LAT_FULL_TURN = 31'd463994880;

    localparam logic [4:0] KNOWN_ID  = 5'b00001;
    localparam logic [4:0] KNOWN_ALT = 5'b00010;
    localparam logic [4:0] KNOWN_LAT = 5'b00100;
    localparam logic [4:0] HAVE_EVEN = 5'b01000;
    localparam logic [4:0] HAVE_ODD  = 5'b10000;

    typedef struct packed {
        logic [23:0]        address;
        logic [4:0]         downlink_format;
        logic [2:0]         capability;
        logic [4:0]         type_code;
        logic [23:0]        parity;
        logic               is_ident;
        logic               is_position;
        logic [2:0]         category;
        logic [47:0]        codes;
        logic signed [16:0] altitude;
        logic [16:0]        cpr_lat;
        logic               cpr_odd;
    } item_t;

    typedef struct packed {
        logic [2:0]         category;
        logic [47:0]        codes;
        logic signed [16:0] altitude;
        logic [16:0]        even_cpr;
        logic [16:0]        odd_cpr;
        logic signed [30:0] latitude;
        logic [4:0]         flags;
    } record_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SEARCH,
        B_FETCH,
        B_UPDATE,
        B_DEC1,
        B_DEC2,
        B_DEC3,
        B_WRITE
    } back_state_t;

    function automatic logic [63:0] callsign_ascii(input logic [47:0] codes);
        logic [63:0] text;
        logic [5:0]  c;
        text = '0;
        for (int i = 0; i < 8; i++) begin
            c = codes[47 - 6 * i -: 6];
            text[63 - 8 * i -: 8] = GLYPH_ROM[511 - 8 * int'(c) -: 8];
        end
        return text;
    endfunction

endpackage

>>> hdl/adsbtt_front.sv
module adsbtt_front (
    input  logic [111:0]          frame,
    output adsbtt_pkg::item_t     item
);

    logic [7:0]  header;
    logic [55:0] me;
    logic [11:0] alt_code;
    logic [10:0] alt_n;

    always_comb begin
        header   = frame[7:0];
        me       = frame[87:32];
        alt_code = me[47:36];
        // The Q bit sits in the middle of the altitude code and is dropped.
        alt_n    = {alt_code[11:5], alt_code[3:0]};

        item.address         = frame[31:8];
        item.downlink_format = header[7:3];
        item.capability      = header[2:0];
        item.type_code       = me[55:51];
        item.parity          = frame[111:88];
        item.is_ident        = me[55:51] inside {[5'd1:5'd4]};
        item.is_position     = me[55:51] inside {[5'd9:5'd18]};
        item.category        = me[50:48];
        item.codes           = me[47:0];
        item.altitude        = $signed(17'(alt_n) * adsbtt_pkg::ALT_STEP
                                       - adsbtt_pkg::ALT_OFFSET);
        item.cpr_lat         = me[33:17];
        item.cpr_odd         = me[34];
    end

endmodule

>>> hdl/adsbtt_queue.sv
module adsbtt_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  adsbtt_pkg::item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output adsbtt_pkg::item_t out_item
);

    adsbtt_pkg::item_t slots_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_item  = slots_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> hdl/adsbtt_back.sv
module adsbtt_back #(
    parameter int TABLE_ENTRIES = adsbtt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  adsbtt_pkg::item_t q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [183:0]      m_data,
    output logic              m_full
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [23:0]              addr_mem [TABLE_ENTRIES];
    adsbtt_pkg::record_t      rec_mem  [TABLE_ENTRIES];
    logic [23:0]              addr_rd_q;
    adsbtt_pkg::record_t      rec_rd_q;

    adsbtt_pkg::back_state_t  state_reg, state_next;
    adsbtt_pkg::item_t        item_reg, item_next;
    adsbtt_pkg::record_t      rec_reg, rec_next;
    logic [CW-1:0]            scan_reg, scan_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     cmpv_reg, cmpv_next;
    logic [IW-1:0]            cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]            slot_reg, slot_next;
    logic                     alloc_reg, alloc_next;
    logic                     full_reg, full_next;
    logic signed [8:0]        j_reg, j_next;
    logic [29:0]              even_reg, even_next;
    logic [29:0]              odd_reg, odd_next;
    logic                     out_valid_reg, out_valid_next;
    logic [183:0]             out_data_reg, out_data_next;
    logic                     out_full_reg, out_full_next;

    logic                     hit, scan_done, table_at_max, out_free, commit, need_dec;
    adsbtt_pkg::record_t      upd;
    logic [25:0]              t_sum;
    logic [5:0]               je, jo;
    logic signed [30:0]       even_s, odd_s;
    logic [2:0]               known;

    assign hit          = cmpv_reg && (addr_rd_q == item_reg.address);
    assign scan_done    = (scan_reg == count_reg);
    assign table_at_max = (count_reg == CW'(TABLE_ENTRIES));
    assign out_free     = !out_valid_reg || m_ready;
    assign commit       = (state_reg == adsbtt_pkg::B_WRITE) && out_free && !full_reg;
    assign q_ready      = (state_reg == adsbtt_pkg::B_IDLE);

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign m_full  = out_full_reg;

    // Record merge for the frame in hand; a fresh slot starts from zero.
    always_comb begin
        upd = alloc_reg ? '0 : rec_rd_q;
        if (item_reg.is_ident) begin
            upd.category = item_reg.category;
            upd.codes    = item_reg.codes;
            upd.flags    = upd.flags | adsbtt_pkg::KNOWN_ID;
        end
        if (item_reg.is_position) begin
            upd.altitude = item_reg.altitude;
            upd.flags    = upd.flags | adsbtt_pkg::KNOWN_ALT;
            if (item_reg.cpr_odd) begin
                upd.odd_cpr = item_reg.cpr_lat;
                upd.flags   = upd.flags | adsbtt_pkg::HAVE_ODD;
            end else begin
                upd.even_cpr = item_reg.cpr_lat;
                upd.flags    = upd.flags | adsbtt_pkg::HAVE_EVEN;
            end
        end
        need_dec = item_reg.is_position && upd.flags[3] && upd.flags[4];
    end

    // Latitude zone index and its two floor remainders; j lies in -60..59.
    always_comb begin
        t_sum = 26'(rec_reg.even_cpr) * 26'd59 - 26'(rec_reg.odd_cpr) * 26'd60
                + adsbtt_pkg::CPR_HALF;
        if (j_reg < 0) begin
            je = 6'(j_reg + 9'sd60);
        end else begin
            je = 6'(j_reg);
        end
        if (j_reg == -9'sd60) begin
            jo = 6'd58;
        end else if (j_reg < 0) begin
            jo = 6'(j_reg + 9'sd59);
        end else if (j_reg == 9'sd59) begin
            jo = 6'd0;
        end else begin
            jo = 6'(j_reg);
        end
        even_s = $signed({1'b0, even_reg});
        odd_s  = $signed({1'b0, odd_reg});
        if ({1'b0, even_reg} >= adsbtt_pkg::LAT_WRAP_AT) begin
            even_s = $signed({1'b0, even_reg} - adsbtt_pkg::LAT_FULL_TURN);
        end
        if ({1'b0, odd_reg} >= adsbtt_pkg::LAT_WRAP_AT) begin
            odd_s = $signed({1'b0, odd_reg} - adsbtt_pkg::LAT_FULL_TURN);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            adsbtt_pkg::B_IDLE: begin
                if (q_valid) begin
                    state_next = adsbtt_pkg::B_SEARCH;
                end
            end
            adsbtt_pkg::B_SEARCH: begin
                if (hit) begin
                    state_next = adsbtt_pkg::B_FETCH;
                end else if (scan_done) begin
                    state_next = table_at_max ? adsbtt_pkg::B_WRITE : adsbtt_pkg::B_FETCH;
                end
            end
            adsbtt_pkg::B_FETCH:  state_next = adsbtt_pkg::B_UPDATE;
            adsbtt_pkg::B_UPDATE: state_next = need_dec ? adsbtt_pkg::B_DEC1
                                                        : adsbtt_pkg::B_WRITE;
            adsbtt_pkg::B_DEC1:   state_next = adsbtt_pkg::B_DEC2;
            adsbtt_pkg::B_DEC2:   state_next = adsbtt_pkg::B_DEC3;
            adsbtt_pkg::B_DEC3:   state_next = adsbtt_pkg::B_WRITE;
            adsbtt_pkg::B_WRITE: begin
                if (out_free) begin
                    state_next = adsbtt_pkg::B_IDLE;
                end
            end
            default: state_next = adsbtt_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        item_next      = item_reg;
        rec_next       = rec_reg;
        scan_next      = scan_reg;
        count_next     = count_reg;
        cmpv_next      = cmpv_reg;
        cmp_idx_next   = cmp_idx_reg;
        slot_next      = slot_reg;
        alloc_next     = alloc_reg;
        full_next      = full_reg;
        j_next         = j_reg;
        even_next      = even_reg;
        odd_next       = odd_reg;
        out_data_next  = out_data_reg;
        out_full_next  = out_full_reg;
        out_valid_next = out_valid_reg && !m_ready;
        known          = rec_reg.flags[2:0];
        case (state_reg)
            adsbtt_pkg::B_IDLE: begin
                item_next = q_item;
                scan_next = '0;
                cmpv_next = 1'b0;
                full_next = 1'b0;
            end
            adsbtt_pkg::B_SEARCH: begin
                if (hit) begin
                    slot_next  = cmp_idx_reg;
                    alloc_next = 1'b0;
                end else if (scan_done) begin
                    full_next  = table_at_max;
                    alloc_next = 1'b1;
                    slot_next  = count_reg[IW-1:0];
                end else begin
                    cmpv_next    = 1'b1;
                    cmp_idx_next = scan_reg[IW-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
            end
            adsbtt_pkg::B_UPDATE: begin
                rec_next = upd;
            end
            adsbtt_pkg::B_DEC1: begin
                j_next = $signed(t_sum[25:17]);
            end
            adsbtt_pkg::B_DEC2: begin
                even_next = 30'({je, rec_reg.even_cpr}) * 30'd59;
                odd_next  = 30'({jo, rec_reg.odd_cpr}) * 30'd60;
            end
            adsbtt_pkg::B_DEC3: begin
                rec_next.latitude = even_s + odd_s;
                rec_next.flags    = rec_reg.flags | adsbtt_pkg::KNOWN_LAT;
            end
            adsbtt_pkg::B_WRITE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_full_next  = full_reg;
                    out_data_next  = '0;
                    out_data_next[23:0]   = item_reg.address;
                    out_data_next[28:24]  = item_reg.downlink_format;
                    out_data_next[31:29]  = item_reg.capability;
                    out_data_next[36:32]  = item_reg.type_code;
                    out_data_next[60:37]  = item_reg.parity;
                    if (!full_reg) begin
                        if (known[0]) begin
                            out_data_next[63:61]  = rec_reg.category;
                            out_data_next[127:64] = adsbtt_pkg::callsign_ascii(rec_reg.codes);
                        end
                        if (known[1]) begin
                            out_data_next[144:128] = rec_reg.altitude;
                        end
                        if (known[2]) begin
                            out_data_next[175:145] = rec_reg.latitude;
                        end
                        out_data_next[178:176] = known;
                        if (alloc_reg) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= adsbtt_pkg::B_IDLE;
            count_reg     <= '0;
            cmpv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmpv_reg      <= cmpv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        rec_reg      <= rec_next;
        scan_reg     <= scan_next;
        cmp_idx_reg  <= cmp_idx_next;
        slot_reg     <= slot_next;
        alloc_reg    <= alloc_next;
        full_reg     <= full_next;
        j_reg        <= j_next;
        even_reg     <= even_next;
        odd_reg      <= odd_next;
        out_data_reg <= out_data_next;
        out_full_reg <= out_full_next;
    end

    always_ff @(posedge aclk) begin
        addr_rd_q <= addr_mem[scan_reg[IW-1:0]];
        if (commit && alloc_reg) begin
            addr_mem[slot_reg] <= item_reg.address;
        end
    end

    always_ff @(posedge aclk) begin
        rec_rd_q <= rec_mem[slot_reg];
        if (commit) begin
            rec_mem[slot_reg] <= rec_reg;
        end
    end

endmodule

>>> hdl/adsb_track_table_decoder_top.sv
// ADS-B extended squitter decoder with an aircraft track table.
// Input stream: one beat per 112-bit frame (header byte, address, ME body,
// parity). Output stream: one beat per frame with the split-out frame
// fields and the stored aircraft state after this frame, zero when tuser
// is set; tuser is set when the address is new and every slot is taken.
// A frame waits in a two-deep queue behind the input port; the sequencer
// then compares the address against the slots in use, one address-memory
// read per cycle, reads and updates the slot record, and runs a fixed-point
// latitude decode once both CPR latitudes are held.
// The sequencer takes a new frame from the queue only once it is idle,
// so frames pass through it one at a time; the address search takes
// most of the time per frame and grows with the number of slots in use.
// Reset empties the table at once: no clearing pass is needed, as the
// slot count alone marks which slots are in use.
// When the receiver stalls, the output register holds its beat; the
// sequencer finishes the next frame and waits, and the queue keeps taking
// input until both of its places are full.
module adsb_track_table_decoder_top #(
    parameter int TABLE_ENTRIES = adsbtt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // header_byte, aircraft_address, message_body, parity_word
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_address, downlink_format, capability, type_code, out_parity,
    // category, callsign_text, altitude_feet, latitude_sum, known_mask, zero pad
    output logic [183:0] m_axis_tdata,
    // table_full
    output logic [0:0]   m_axis_tuser
);

    adsbtt_pkg::item_t front_item, q_item;
    logic              q_valid, q_ready;
    logic              full_flag;

    adsbtt_front u_front (
        .frame (s_axis_tdata),
        .item  (front_item)
    );

    adsbtt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    adsbtt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_full  (full_flag)
    );

    assign m_axis_tuser = full_flag;

endmodule

>>> hdl/adsbtt_checker.sv
module adsbtt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [183:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[183:61] == '0)
        else $error("aircraft fields set on a table-full beat");

    a_lat_needs_alt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[178] |-> m_axis_tdata[177])
        else $error("latitude known without altitude");

endmodule

bind adsb_track_table_decoder_top adsbtt_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
